[rtl/core/hdm_pkg.sv]
`default_nettype none

package hdm_pkg;

    // fixed point format of the drive values
    localparam int FRAC_BITS = 8;

    // field widths
    localparam int AXIS_W  = 8;
    localparam int FS_W    = 7;
    localparam int DRIVE_W = 16;

    // internal widths
    localparam int MAG_W  = AXIS_W;             // axis magnitude, 0..128
    localparam int SUM_W  = MAG_W + 1;          // |f| + |s|
    localparam int VAL_W  = MAG_W + FRAC_BITS + 2;  // signed wheel value before scaling
    localparam int VMAG_W = VAL_W - 1;          // wheel value magnitude
    localparam int FSF_W  = FS_W + FRAC_BITS;   // full scale in fixed point

    // shared restoring divider geometry
    localparam int DIV_NW     = VMAG_W + FSF_W;
    localparam int DIV_DW     = VMAG_W;
    localparam int DIV_QW     = DRIVE_W;
    localparam int DIV_STAGES = DIV_QW;
    localparam int DIV_PAD    = DIV_DW - (DIV_NW - DIV_QW);

    // number of wheels
    localparam int WHEELS = 4;

    // configuration port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;
    localparam logic [CFG_AW-3:0] REG_FULL_SCALE = 1'b0;
    localparam logic [FS_W-1:0]   FS_RESET       = 7'd100;

    // what travels beside the mix divider
    typedef struct packed {
        logic [MAG_W-1:0]         mx;
        logic                     a_neg;
        logic                     b_neg;
        logic                     same;
        logic                     zero;
        logic signed [AXIS_W-1:0] t;
    } t_side1;

    // what travels beside the normalizing dividers
    typedef struct packed {
        logic [WHEELS-1:0] neg;
        logic              mz;
    } t_side2;

    typedef logic [WHEELS-1:0][DIV_QW-1:0] t_quo4;

endpackage

`default_nettype wire

[rtl/core/hdm_cfg.sv]
`default_nettype none

module hdm_cfg
    import hdm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready,
    output logic      [FS_W-1:0]   o_full_scale
);

    logic [FS_W-1:0] r_full_scale;
    logic            w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // full scale register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_scale <= FS_RESET;
        end else if (w_wr && paddr[CFG_AW-1:2] == REG_FULL_SCALE) begin
            r_full_scale <= pwdata[FS_W-1:0];
        end
    end

    // read decode
    always_comb begin
        unique case (paddr[CFG_AW-1:2])
            REG_FULL_SCALE: prdata = {{(CFG_DW-FS_W){1'b0}}, r_full_scale};
            default:        prdata = '0;
        endcase
    end

    assign o_full_scale = r_full_scale;

endmodule

`default_nettype wire

[rtl/core/hdm_div.sv]
`default_nettype none

module hdm_div
    import hdm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [DIV_NW-1:0] i_num,
    input  wire logic [DIV_DW-1:0] i_den,
    output logic                   o_valid,
    output logic      [DIV_QW-1:0] o_quo
);

    // one quotient bit per stage; the quotient is known to fit in DIV_QW bits,
    // so the upper dividend bits seed the partial remainder directly
    logic [DIV_STAGES-1:0] r_valid;
    logic [DIV_DW-1:0]     r_rem [DIV_STAGES];
    logic [DIV_DW-1:0]     r_den [DIV_STAGES];
    logic [DIV_QW-1:0]     r_quo [DIV_STAGES];
    logic [DIV_QW-1:0]     r_lo  [DIV_STAGES-1];

    logic [DIV_DW-1:0]     w_rem [DIV_STAGES];
    logic [DIV_DW-1:0]     w_den [DIV_STAGES];
    logic [DIV_QW-1:0]     w_quo [DIV_STAGES];
    logic [DIV_QW-1:0]     w_lo  [DIV_STAGES];
    logic [DIV_DW:0]       w_trial [DIV_STAGES];
    logic [DIV_STAGES-1:0] w_fit;
    logic [DIV_DW-1:0]     n_rem [DIV_STAGES];
    logic [DIV_QW-1:0]     n_quo [DIV_STAGES];
    logic [DIV_QW-1:0]     n_lo  [DIV_STAGES-1];

    // stage inputs
    always_comb begin
        w_rem[0] = {{DIV_PAD{1'b0}}, i_num[DIV_NW-1:DIV_QW]};
        w_den[0] = i_den;
        w_quo[0] = '0;
        w_lo[0]  = i_num[DIV_QW-1:0];
        for (int k = 1; k < DIV_STAGES; k++) begin
            w_rem[k] = r_rem[k-1];
            w_den[k] = r_den[k-1];
            w_quo[k] = r_quo[k-1];
            w_lo[k]  = r_lo[k-1];
        end
    end

    // compare and subtract in every stage
    always_comb begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            w_trial[k] = {w_rem[k], w_lo[k][DIV_QW-1]};
            w_fit[k]   = w_trial[k] >= {1'b0, w_den[k]};
            n_rem[k]   = w_fit[k] ? DIV_DW'(w_trial[k] - {1'b0, w_den[k]})
                                  : w_trial[k][DIV_DW-1:0];
            n_quo[k]   = {w_quo[k][DIV_QW-2:0], w_fit[k]};
        end
        for (int k = 0; k < DIV_STAGES - 1; k++) begin
            n_lo[k] = {w_lo[k][DIV_QW-2:0], 1'b0};
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[DIV_STAGES-2:0], i_valid};
        end
    end

    // stage data
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= w_den[k];
                r_quo[k] <= n_quo[k];
            end
            for (int k = 0; k < DIV_STAGES - 1; k++) begin
                r_lo[k] <= n_lo[k];
            end
        end
    end

    assign o_valid = r_valid[DIV_STAGES-1];
    assign o_quo   = r_quo[DIV_STAGES-1];

    // the final remainder is below the divisor whenever the quotient fits
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[DIV_STAGES-1] |->
            (r_den[DIV_STAGES-1] == '0 || r_rem[DIV_STAGES-1] < r_den[DIV_STAGES-1]))
        else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

[rtl/core/hdm_front.sv]
`default_nettype none

module hdm_front
    import hdm_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_valid,
    input  wire logic signed [AXIS_W-1:0] i_forward_axis,
    input  wire logic signed [AXIS_W-1:0] i_strafe_axis,
    input  wire logic signed [AXIS_W-1:0] i_turn_axis,
    output logic                          o_valid,
    output logic             [DIV_QW-1:0] o_quo,
    output t_side1                        o_side
);

    // one of the two mixes is always +-max*F; the other has magnitude
    // (max-min)*max*F/(max+min), which is the only division needed here
    logic [MAG_W-1:0]   w_af;
    logic [MAG_W-1:0]   w_as;
    logic [AXIS_W:0]    w_dp;
    logic [AXIS_W:0]    w_dm;
    t_side1             w_side;
    logic [MAG_W-1:0]   w_mn;

    logic               r_a_valid;
    t_side1             r_a_side;
    logic [MAG_W-1:0]   r_a_mn;

    logic [2*MAG_W-1:0] w_prod;
    logic [SUM_W-1:0]   w_sum;

    logic               r_b_valid;
    t_side1             r_b_side;
    logic [DIV_NW-1:0]  r_b_num;
    logic [DIV_DW-1:0]  r_b_den;

    t_side1             r_side_dly [DIV_STAGES];

    // stage a: magnitudes, ordering and signs
    always_comb begin
        w_af = i_forward_axis[AXIS_W-1] ? MAG_W'(-i_forward_axis) : MAG_W'(i_forward_axis);
        w_as = i_strafe_axis[AXIS_W-1]  ? MAG_W'(-i_strafe_axis)  : MAG_W'(i_strafe_axis);
        w_dp = {i_forward_axis[AXIS_W-1], i_forward_axis}
             + {i_strafe_axis[AXIS_W-1], i_strafe_axis};
        w_dm = {i_forward_axis[AXIS_W-1], i_forward_axis}
             - {i_strafe_axis[AXIS_W-1], i_strafe_axis};
        w_side.mx    = (w_af > w_as) ? w_af : w_as;
        w_mn         = (w_af > w_as) ? w_as : w_af;
        w_side.a_neg = w_dp[AXIS_W];
        w_side.b_neg = w_dm[AXIS_W];
        w_side.same  = i_forward_axis[AXIS_W-1] == i_strafe_axis[AXIS_W-1];
        w_side.zero  = (w_af == '0) && (w_as == '0);
        w_side.t     = i_turn_axis;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_side <= w_side;
            r_a_mn   <= w_mn;
        end
    end

    // stage b: dividend and divisor
    assign w_prod = {{MAG_W{1'b0}}, r_a_side.mx - r_a_mn} * {{MAG_W{1'b0}}, r_a_side.mx};
    assign w_sum  = {1'b0, r_a_side.mx} + {1'b0, r_a_mn};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_side <= r_a_side;
            r_b_num  <= DIV_NW'({w_prod, {FRAC_BITS{1'b0}}});
            r_b_den  <= {{(DIV_DW-SUM_W){1'b0}}, w_sum};
        end
    end

    // mix divider
    hdm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_b_valid),
        .i_num   (r_b_num),
        .i_den   (r_b_den),
        .o_valid (o_valid),
        .o_quo   (o_quo)
    );

    // side data delayed to match the divider
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side_dly[0] <= r_b_side;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_side_dly[k] <= r_side_dly[k-1];
            end
        end
    end

    assign o_side = r_side_dly[DIV_STAGES-1];

endmodule

`default_nettype wire

[rtl/core/hdm_scale.sv]
`default_nettype none

module hdm_scale
    import hdm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [DIV_QW-1:0] i_quo,
    input  wire t_side1            i_side,
    input  wire logic [FS_W-1:0]   i_full_scale,
    output logic                   o_valid,
    output t_quo4                  o_quo,
    output t_side2                 o_side
);

    logic [DIV_QW-1:0]       w_q;
    logic [DIV_QW-1:0]       w_big;
    logic [DIV_QW-1:0]       w_amag;
    logic [DIV_QW-1:0]       w_bmag;
    logic signed [VAL_W-1:0] w_a_pos;
    logic signed [VAL_W-1:0] w_b_pos;

    logic                    r_c_valid;
    logic signed [VAL_W-1:0] r_c_a;
    logic signed [VAL_W-1:0] r_c_b;
    logic signed [VAL_W-1:0] r_c_tf;

    logic signed [VAL_W-1:0] w_v  [WHEELS];
    logic signed [VAL_W-1:0] w_nv [WHEELS];

    logic                    r_d_valid;
    logic [VMAG_W-1:0]       r_d_mag [WHEELS];
    logic [WHEELS-1:0]       r_d_neg;

    logic [FSF_W-1:0]        w_fs;
    logic [VMAG_W-1:0]       w_m01;
    logic [VMAG_W-1:0]       w_m23;
    logic [VMAG_W-1:0]       w_mv;
    logic [VMAG_W-1:0]       w_m;

    logic                    r_e_valid;
    logic [DIV_NW-1:0]       r_e_prod [WHEELS];
    logic [DIV_DW-1:0]       r_e_den;
    t_side2                  r_e_side;

    logic [WHEELS-1:0]       w_div_valid;
    t_side2                  r_side_dly [DIV_STAGES];

    // stage c: rebuild both mixes and the turn term
    always_comb begin
        w_q     = i_side.zero ? '0 : i_quo;
        w_big   = DIV_QW'({i_side.mx, {FRAC_BITS{1'b0}}});
        w_amag  = i_side.same ? w_big : w_q;
        w_bmag  = i_side.same ? w_q : w_big;
        w_a_pos = $signed({{(VAL_W-DIV_QW){1'b0}}, w_amag});
        w_b_pos = $signed({{(VAL_W-DIV_QW){1'b0}}, w_bmag});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_c_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_a  <= i_side.a_neg ? -w_a_pos : w_a_pos;
            r_c_b  <= i_side.b_neg ? -w_b_pos : w_b_pos;
            r_c_tf <= $signed({{(VAL_W-AXIS_W-FRAC_BITS){i_side.t[AXIS_W-1]}},
                               i_side.t, {FRAC_BITS{1'b0}}});
        end
    end

    // stage d: wheel values, split into sign and magnitude
    always_comb begin
        w_v[0] = r_c_a + r_c_tf;
        w_v[1] = r_c_b + r_c_tf;
        w_v[2] = r_c_b - r_c_tf;
        w_v[3] = r_c_a - r_c_tf;
        for (int i = 0; i < WHEELS; i++) begin
            w_nv[i] = -w_v[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (i_en) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < WHEELS; i++) begin
                r_d_mag[i] <= w_v[i][VAL_W-1] ? w_nv[i][VMAG_W-1:0] : w_v[i][VMAG_W-1:0];
                r_d_neg[i] <= w_v[i][VAL_W-1];
            end
        end
    end

    // stage e: normalizer and scaled numerators
    always_comb begin
        w_fs  = {i_full_scale, {FRAC_BITS{1'b0}}};
        w_m01 = (r_d_mag[0] > r_d_mag[1]) ? r_d_mag[0] : r_d_mag[1];
        w_m23 = (r_d_mag[2] > r_d_mag[3]) ? r_d_mag[2] : r_d_mag[3];
        w_mv  = (w_m01 > w_m23) ? w_m01 : w_m23;
        w_m   = (w_mv > {{(VMAG_W-FSF_W){1'b0}}, w_fs}) ? w_mv
                                                          : {{(VMAG_W-FSF_W){1'b0}}, w_fs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (i_en) begin
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < WHEELS; i++) begin
                r_e_prod[i] <= {{FSF_W{1'b0}}, r_d_mag[i]} * {{VMAG_W{1'b0}}, w_fs};
            end
            r_e_den      <= w_m;
            r_e_side.neg <= r_d_neg;
            r_e_side.mz  <= (w_m == '0);
        end
    end

    // one normalizing divider per wheel, all sharing the divisor
    for (genvar g = 0; g < WHEELS; g++) begin : g_div
        hdm_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (r_e_valid),
            .i_num   (r_e_prod[g]),
            .i_den   (r_e_den),
            .o_valid (w_div_valid[g]),
            .o_quo   (o_quo[g])
        );
    end

    // signs delayed to match the dividers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side_dly[0] <= r_e_side;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_side_dly[k] <= r_side_dly[k-1];
            end
        end
    end

    assign o_valid = &w_div_valid;
    assign o_side  = r_side_dly[DIV_STAGES-1];

endmodule

`default_nettype wire

[rtl/core/holonomic_drive_mixer_unit.sv]
// channel   direction  handshake             payload
// input     in         i_valid / o_stall     i_forward_axis, i_strafe_axis, i_turn_axis
// output    out        o_valid / i_stall     o_front_left_drive, o_back_left_drive,
//                                            o_front_right_drive, o_back_right_drive
// config    in         APB (psel, penable)   full_scale at byte address 0
//
// one transaction per cycle sustained unless the output stalls; input accept and
// output valid are set apart by two 16-stage restoring dividers plus 6 other stages
// synchronous active-low reset clears all valid bits and loads full_scale = 100
// a stalled output freezes the whole pipeline; o_stall is high only while a
// result is held waiting on i_stall
`default_nettype none

module holonomic_drive_mixer_unit
    import hdm_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // input channel
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic signed [AXIS_W-1:0]  i_forward_axis,
    input  wire logic signed [AXIS_W-1:0]  i_strafe_axis,
    input  wire logic signed [AXIS_W-1:0]  i_turn_axis,
    // output channel
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic signed [DRIVE_W-1:0]      o_front_left_drive,
    output logic signed [DRIVE_W-1:0]      o_back_left_drive,
    output logic signed [DRIVE_W-1:0]      o_front_right_drive,
    output logic signed [DRIVE_W-1:0]      o_back_right_drive,
    // configuration
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [CFG_AW-1:0]         paddr,
    input  wire logic [CFG_DW-1:0]         pwdata,
    output logic      [CFG_DW-1:0]         prdata,
    output logic                           pready
);

    logic              w_en;
    logic [FS_W-1:0]   w_full_scale;

    logic              w_mix_valid;
    logic [DIV_QW-1:0] w_mix_quo;
    t_side1            w_mix_side;

    logic              w_scl_valid;
    t_quo4             w_scl_quo;
    t_side2            w_scl_side;

    logic [DRIVE_W-1:0] w_drive [WHEELS];

    logic               r_out_valid;
    logic [DRIVE_W-1:0] r_drive [WHEELS];

    // pipeline advances unless a held result is stalled
    assign w_en    = !r_out_valid || !i_stall;
    assign o_stall = !w_en;

    hdm_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_full_scale (w_full_scale)
    );

    hdm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_valid        (i_valid),
        .i_forward_axis (i_forward_axis),
        .i_strafe_axis  (i_strafe_axis),
        .i_turn_axis    (i_turn_axis),
        .o_valid        (w_mix_valid),
        .o_quo          (w_mix_quo),
        .o_side         (w_mix_side)
    );

    hdm_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_valid      (w_mix_valid),
        .i_quo        (w_mix_quo),
        .i_side       (w_mix_side),
        .i_full_scale (w_full_scale),
        .o_valid      (w_scl_valid),
        .o_quo        (w_scl_quo),
        .o_side       (w_scl_side)
    );

    // restore signs; a zero normalizer gives zero drives
    always_comb begin
        for (int i = 0; i < WHEELS; i++) begin
            if (w_scl_side.mz) begin
                w_drive[i] = '0;
            end else if (w_scl_side.neg[i]) begin
                w_drive[i] = DRIVE_W'(-w_scl_quo[i]);
            end else begin
                w_drive[i] = w_scl_quo[i];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_scl_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < WHEELS; i++) begin
                r_drive[i] <= w_drive[i];
            end
        end
    end

    assign o_valid             = r_out_valid;
    assign o_front_left_drive  = $signed(r_drive[0]);
    assign o_back_left_drive   = $signed(r_drive[1]);
    assign o_front_right_drive = $signed(r_drive[2]);
    assign o_back_right_drive  = $signed(r_drive[3]);

    // input is only held off while a result waits
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result pending");

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

`default_nettype wire
